>>> sv/y86_pkg.sv
// Shared types and constants for the Y86-64 instruction execute block.
// Holds opcodes, status codes, the decoded-instruction record and CSR indexes.
// No dependencies.
package y86_pkg;

   localparam int REG_COUNT  = 16;
   localparam int REG_IDX_W  = 4;
   localparam int SP_REG     = 4;
   localparam int WORD_BYTES = 8;

   localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

   localparam logic [4:0] OP_NOP     = 5'd0;
   localparam logic [4:0] OP_HALT    = 5'd1;
   localparam logic [4:0] OP_RRMOVQ  = 5'd2;
   localparam logic [4:0] OP_IRMOVQ  = 5'd3;
   localparam logic [4:0] OP_RMMOVQ  = 5'd4;
   localparam logic [4:0] OP_MRMOVQ  = 5'd5;
   localparam logic [4:0] OP_PUSHQ   = 5'd6;
   localparam logic [4:0] OP_POPQ    = 5'd7;
   localparam logic [4:0] OP_CALL    = 5'd8;
   localparam logic [4:0] OP_RET     = 5'd9;
   localparam logic [4:0] OP_JMP     = 5'd10;
   localparam logic [4:0] OP_JEQ     = 5'd11;
   localparam logic [4:0] OP_JNE     = 5'd12;
   localparam logic [4:0] OP_JL      = 5'd13;
   localparam logic [4:0] OP_JLE     = 5'd14;
   localparam logic [4:0] OP_JG      = 5'd15;
   localparam logic [4:0] OP_JGE     = 5'd16;
   localparam logic [4:0] OP_ADDQ    = 5'd17;
   localparam logic [4:0] OP_SUBQ    = 5'd18;
   localparam logic [4:0] OP_MULQ    = 5'd19;
   localparam logic [4:0] OP_MODQ    = 5'd20;
   localparam logic [4:0] OP_DIVQ    = 5'd21;
   localparam logic [4:0] OP_ANDQ    = 5'd22;
   localparam logic [4:0] OP_XORQ    = 5'd23;
   localparam logic [4:0] OP_CMOVEQ  = 5'd24;
   localparam logic [4:0] OP_CMOVNE  = 5'd25;
   localparam logic [4:0] OP_CMOVL   = 5'd26;
   localparam logic [4:0] OP_CMOVLE  = 5'd27;
   localparam logic [4:0] OP_CMOVG   = 5'd28;
   localparam logic [4:0] OP_CMOVGE  = 5'd29;

   localparam logic [2:0] ST_OK   = 3'd0;
   localparam logic [2:0] ST_HALT = 3'd1;
   localparam logic [2:0] ST_ADDR = 3'd2;
   localparam logic [2:0] ST_DIV0 = 3'd3;
   localparam logic [2:0] ST_INV  = 3'd4;

   localparam logic CSR_MEM_BASE = 1'b0;
   localparam logic CSR_MEM_USED = 1'b1;

   typedef enum logic [3:0] {
      CLS_NOP, CLS_HALT, CLS_RRMOV, CLS_IRMOV, CLS_RMMOV, CLS_MRMOV, CLS_PUSH, CLS_POP,
      CLS_CALL, CLS_RET, CLS_JUMP, CLS_ALU, CLS_MUL, CLS_DIV, CLS_CMOV, CLS_INV
   } cls_type;

   typedef enum logic [2:0] {
      COND_ALWAYS, COND_EQ, COND_NE, COND_LT, COND_LE, COND_GT, COND_GE
   } cond_type;

   typedef enum logic [2:0] {
      ALU_ADD, ALU_SUB, ALU_AND, ALU_XOR, ALU_MOD, ALU_DIV
   } alu_type;

   typedef struct packed {
      cls_type         cls;
      cond_type        cond;
      alu_type         alu;
      logic [3:0]      ra;
      logic [3:0]      rb;
      logic [63:0]     vc;
   } dec_type;

endpackage

>>> sv/y86_front.sv
// Front end: accepts instruction transactions and classifies the opcode.
// Depends on y86_pkg; feeds the decoded record into y86_queue.
module y86_front (
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [4:0]       req_type,
   input  logic [3:0]       req_reg_a,
   input  logic [3:0]       req_reg_b,
   input  logic [63:0]      req_const_val,
   input  logic             q_full,
   input  logic             clearing,
   output logic             push,
   output y86_pkg::dec_type dec
);
   import y86_pkg::*;

   assign req_ready = !q_full && !clearing;
   assign push      = req_valid && req_ready;

   always_comb begin
      dec.cls  = CLS_INV;
      dec.cond = COND_ALWAYS;
      dec.alu  = ALU_ADD;
      dec.ra   = req_reg_a;
      dec.rb   = req_reg_b;
      dec.vc   = req_const_val;
      unique case (req_type)
         OP_NOP:    dec.cls = CLS_NOP;
         OP_HALT:   dec.cls = CLS_HALT;
         OP_RRMOVQ: dec.cls = CLS_RRMOV;
         OP_IRMOVQ: dec.cls = CLS_IRMOV;
         OP_RMMOVQ: dec.cls = CLS_RMMOV;
         OP_MRMOVQ: dec.cls = CLS_MRMOV;
         OP_PUSHQ:  dec.cls = CLS_PUSH;
         OP_POPQ:   dec.cls = CLS_POP;
         OP_CALL:   dec.cls = CLS_CALL;
         OP_RET:    dec.cls = CLS_RET;
         OP_JMP:    dec.cls = CLS_JUMP;
         OP_JEQ: begin
            dec.cls  = CLS_JUMP;
            dec.cond = COND_EQ;
         end
         OP_JNE: begin
            dec.cls  = CLS_JUMP;
            dec.cond = COND_NE;
         end
         OP_JL: begin
            dec.cls  = CLS_JUMP;
            dec.cond = COND_LT;
         end
         OP_JLE: begin
            dec.cls  = CLS_JUMP;
            dec.cond = COND_LE;
         end
         OP_JG: begin
            dec.cls  = CLS_JUMP;
            dec.cond = COND_GT;
         end
         OP_JGE: begin
            dec.cls  = CLS_JUMP;
            dec.cond = COND_GE;
         end
         OP_ADDQ:   dec.cls = CLS_ALU;
         OP_SUBQ: begin
            dec.cls = CLS_ALU;
            dec.alu = ALU_SUB;
         end
         OP_MULQ:   dec.cls = CLS_MUL;
         OP_MODQ: begin
            dec.cls = CLS_DIV;
            dec.alu = ALU_MOD;
         end
         OP_DIVQ: begin
            dec.cls = CLS_DIV;
            dec.alu = ALU_DIV;
         end
         OP_ANDQ: begin
            dec.cls = CLS_ALU;
            dec.alu = ALU_AND;
         end
         OP_XORQ: begin
            dec.cls = CLS_ALU;
            dec.alu = ALU_XOR;
         end
         OP_CMOVEQ: begin
            dec.cls  = CLS_CMOV;
            dec.cond = COND_EQ;
         end
         OP_CMOVNE: begin
            dec.cls  = CLS_CMOV;
            dec.cond = COND_NE;
         end
         OP_CMOVL: begin
            dec.cls  = CLS_CMOV;
            dec.cond = COND_LT;
         end
         OP_CMOVLE: begin
            dec.cls  = CLS_CMOV;
            dec.cond = COND_LE;
         end
         OP_CMOVG: begin
            dec.cls  = CLS_CMOV;
            dec.cond = COND_GT;
         end
         OP_CMOVGE: begin
            dec.cls  = CLS_CMOV;
            dec.cond = COND_GE;
         end
         default:   dec.cls = CLS_INV;
      endcase
   end

endmodule

>>> sv/y86_queue.sv
// Two-entry queue of decoded instructions between the front and back ends.
// Depends on y86_pkg for the decoded record type.
module y86_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  y86_pkg::dec_type wdata,
   input  logic             pop,
   output logic             full,
   output logic             valid,
   output y86_pkg::dec_type rdata
);
   import y86_pkg::*;

   dec_type    entries_ff [2];
   logic       wp_ff;
   logic       rp_ff;
   logic [1:0] cnt_ff;

   assign full  = cnt_ff == 2'd2;
   assign valid = cnt_ff != 2'd0;
   assign rdata = entries_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wp_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= !wp_ff;
         end
         if (pop) begin
            rp_ff <= !rp_ff;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

endmodule

>>> sv/y86_div.sv
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
// No package dependencies; used by y86_back.
module y86_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient,
   output logic [63:0] remainder
);
   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] rem_ff;
   logic [63:0] quo_ff;
   logic [63:0] d_ff;
   logic [64:0] shifted;
   logic [64:0] diff;

   assign shifted   = {rem_ff, quo_ff[63]};
   assign diff      = shifted - {1'b0, d_ff};
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= dividend;
            d_ff    <= divisor;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (!diff[64]) begin
               rem_ff <= diff[63:0];
               quo_ff <= {quo_ff[62:0], 1'b1};
            end else begin
               rem_ff <= shifted[63:0];
               quo_ff <= {quo_ff[62:0], 1'b0};
            end
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

>>> sv/y86_back.sv
// Back end: sequencer that executes one decoded instruction at a time against
// the register file, byte memory, PC and flags. Depends on y86_pkg and y86_div.
module y86_back #(
   parameter int MEM_BYTES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  y86_pkg::dec_type q_data,
   output logic             q_pop,
   input  logic [63:0]      mem_base,
   input  logic [10:0]      mem_used,
   output logic             clearing,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [63:0]      rsp_next_pc,
   output logic             rsp_zero_flag,
   output logic             rsp_sign_flag,
   output logic             rsp_overflow_flag
);
   import y86_pkg::*;

   localparam int AW = $clog2(MEM_BYTES);
   localparam logic [63:0]   MEM_BYTES64 = 64'(MEM_BYTES);
   localparam logic [AW-1:0] LAST_BYTE   = AW'(MEM_BYTES - 1);
   localparam logic [3:0]    LAST_STORE  = 4'(WORD_BYTES - 1);
   localparam logic [3:0]    LAST_LOAD   = 4'(WORD_BYTES);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RDSP, S_EXEC, S_ACHK, S_MEMOP, S_MUL, S_MULFIN,
      S_DIV, S_WBSP, S_WBRES, S_FIN
   } state_type;

   state_type   state_ff;
   dec_type     it_ff;
   logic [63:0] a_ff, b_ff, pc_ff, pc_new_ff, res_ff, spv_ff, addr_ff, st_data_ff, ld_ff;
   logic [2:0]  flg_ff, flg_new_ff, st_ff;
   logic [3:0]  dst_ff;
   logic        wres_ff, wsp_ff, mem_wr_ff, ld_pc_ff, ld_res_ff;
   logic [AW-1:0] off_ff, clr_ff;
   logic [3:0]  cnt_ff;
   logic [2:0]  mcnt_ff;
   logic [63:0] ma_ff, mb_ff, prod_ff;
   logic        neg_ff;
   logic [127:0] acc_ff;
   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic [63:0] rsp_pc_ff;
   logic [2:0]  rsp_flags_ff;

   logic [63:0] rf_mem_ff [REG_COUNT];
   logic [REG_COUNT-1:0] rf_vld_ff;
   logic [63:0] rf_q0_ff, rf_q1_ff;
   logic [7:0]  dm_mem_ff [MEM_BYTES];
   logic [7:0]  dm_q_ff;

   logic [3:0]  rf_ra0, rf_ra1, rf_wa;
   logic        rf_we;
   logic [63:0] rf_wd;
   logic        dm_we;
   logic [AW-1:0] dm_addr;
   logic [7:0]  dm_wd;

   logic [63:0] sp_rd, alu_r, size64, win_off, ld_next, mlo, mres, div_r, quo, rem;
   logic        alu_of, win_ok, mof, cond_hit, div_start, div_done;
   logic [31:0] mul_a_half, mul_b_half;

   function automatic logic cond_ok(cond_type c, logic [2:0] f);
      logic lt;
      lt = f[1] ^ f[2];
      unique case (c)
         COND_EQ: cond_ok = f[0];
         COND_NE: cond_ok = !f[0];
         COND_LT: cond_ok = lt;
         COND_LE: cond_ok = lt || f[0];
         COND_GT: cond_ok = !lt && !f[0];
         COND_GE: cond_ok = !lt;
         default: cond_ok = 1'b1;
      endcase
   endfunction

   y86_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (b_ff),
      .divisor   (a_ff),
      .done      (div_done),
      .quotient  (quo),
      .remainder (rem)
   );

   assign sp_rd     = rf_q1_ff;
   assign cond_hit  = cond_ok(it_ff.cond, flg_ff);
   assign q_pop     = (state_ff == S_IDLE) && q_valid;
   assign clearing  = state_ff == S_CLEAR;
   assign div_start = (state_ff == S_EXEC) && (it_ff.cls == CLS_DIV) && (a_ff != '0);
   assign div_r     = (it_ff.alu == ALU_MOD) ? rem : quo;
   assign ld_next   = {dm_q_ff, ld_ff[63:8]};

   always_comb begin
      rf_ra0 = it_ff.ra;
      rf_ra1 = it_ff.rb;
      if (state_ff == S_IDLE) begin
         rf_ra0 = q_data.ra;
         rf_ra1 = q_data.rb;
      end else if (state_ff == S_RDSP) begin
         rf_ra1 = REG_IDX_W'(SP_REG);
      end
      rf_we = ((state_ff == S_WBSP) && wsp_ff) || ((state_ff == S_WBRES) && wres_ff);
      rf_wa = (state_ff == S_WBSP) ? REG_IDX_W'(SP_REG) : dst_ff;
      rf_wd = (state_ff == S_WBSP) ? spv_ff : res_ff;
      dm_we = (state_ff == S_CLEAR) || ((state_ff == S_MEMOP) && mem_wr_ff);
      dm_addr = (state_ff == S_CLEAR) ? clr_ff : off_ff + AW'(cnt_ff[2:0]);
      dm_wd = (state_ff == S_CLEAR) ? 8'h00 : st_data_ff[7:0];
   end

   always_comb begin
      unique case (it_ff.alu)
         ALU_ADD: begin
            alu_r  = b_ff + a_ff;
            alu_of = !(a_ff[63] ^ b_ff[63]) && (alu_r[63] ^ b_ff[63]);
         end
         ALU_SUB: begin
            alu_r  = b_ff - a_ff;
            alu_of = (a_ff[63] ^ b_ff[63]) && (alu_r[63] ^ b_ff[63]);
         end
         ALU_AND: begin
            alu_r  = b_ff & a_ff;
            alu_of = 1'b0;
         end
         ALU_XOR: begin
            alu_r  = b_ff ^ a_ff;
            alu_of = 1'b0;
         end
         default: begin
            alu_r  = '0;
            alu_of = 1'b0;
         end
      endcase
   end

   always_comb begin
      size64  = ({53'd0, mem_used} > MEM_BYTES64) ? MEM_BYTES64 : {53'd0, mem_used};
      win_off = addr_ff - mem_base;
      win_ok  = (addr_ff >= mem_base) && (size64 >= 64'(WORD_BYTES))
                && (win_off <= size64 - 64'(WORD_BYTES));
   end

   always_comb begin
      mul_a_half = mcnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
      mul_b_half = mcnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
      mlo  = acc_ff[63:0];
      mres = neg_ff ? (64'd0 - mlo) : mlo;
      mof  = (|acc_ff[127:64]) || (neg_ff ? (mlo > SIGN64) : (mlo >= SIGN64));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff <= '0;
      end else if (rf_we) begin
         rf_vld_ff[rf_wa] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem_ff[rf_wa] <= rf_wd;
      end
      rf_q0_ff <= rf_vld_ff[rf_ra0] ? rf_mem_ff[rf_ra0] : '0;
      rf_q1_ff <= rf_vld_ff[rf_ra1] ? rf_mem_ff[rf_ra1] : '0;
   end

   always_ff @(posedge clock) begin
      if (dm_we) begin
         dm_mem_ff[dm_addr] <= dm_wd;
      end
      dm_q_ff <= dm_mem_ff[dm_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pc_ff        <= '0;
         flg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         wres_ff      <= 1'b0;
         wsp_ff       <= 1'b0;
         mem_wr_ff    <= 1'b0;
         st_ff        <= ST_OK;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != S_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == LAST_BYTE) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (q_valid) begin
                  it_ff    <= q_data;
                  state_ff <= S_RDSP;
               end
            end
            S_RDSP: begin
               a_ff     <= rf_q0_ff;
               b_ff     <= rf_q1_ff;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               st_ff      <= ST_OK;
               wres_ff    <= 1'b0;
               wsp_ff     <= 1'b0;
               mem_wr_ff  <= 1'b0;
               ld_pc_ff   <= 1'b0;
               ld_res_ff  <= 1'b0;
               pc_new_ff  <= pc_ff;
               flg_new_ff <= flg_ff;
               dst_ff     <= it_ff.rb;
               res_ff     <= a_ff;
               spv_ff     <= sp_rd;
               st_data_ff <= a_ff;
               addr_ff    <= sp_rd;
               cnt_ff     <= '0;
               mcnt_ff    <= '0;
               state_ff   <= S_WBRES;
               unique case (it_ff.cls)
                  CLS_NOP:  pc_new_ff <= pc_ff + 64'd1;
                  CLS_HALT: st_ff <= ST_HALT;
                  CLS_RRMOV: begin
                     wres_ff   <= 1'b1;
                     pc_new_ff <= pc_ff + 64'd2;
                  end
                  CLS_IRMOV: begin
                     wres_ff   <= 1'b1;
                     res_ff    <= it_ff.vc;
                     pc_new_ff <= pc_ff + 64'd10;
                  end
                  CLS_RMMOV: begin
                     addr_ff   <= it_ff.vc + b_ff;
                     mem_wr_ff <= 1'b1;
                     pc_new_ff <= pc_ff + 64'd10;
                     state_ff  <= S_ACHK;
                  end
                  CLS_MRMOV: begin
                     addr_ff   <= it_ff.vc + b_ff;
                     dst_ff    <= it_ff.ra;
                     ld_res_ff <= 1'b1;
                     wres_ff   <= 1'b1;
                     pc_new_ff <= pc_ff + 64'd10;
                     state_ff  <= S_ACHK;
                  end
                  CLS_PUSH: begin
                     addr_ff   <= sp_rd - 64'd8;
                     spv_ff    <= sp_rd - 64'd8;
                     mem_wr_ff <= 1'b1;
                     wsp_ff    <= 1'b1;
                     pc_new_ff <= pc_ff + 64'd2;
                     state_ff  <= S_ACHK;
                  end
                  CLS_POP: begin
                     spv_ff    <= sp_rd + 64'd8;
                     wsp_ff    <= 1'b1;
                     dst_ff    <= it_ff.ra;
                     ld_res_ff <= 1'b1;
                     wres_ff   <= 1'b1;
                     pc_new_ff <= pc_ff + 64'd2;
                     state_ff  <= S_ACHK;
                  end
                  CLS_CALL: begin
                     addr_ff    <= sp_rd - 64'd8;
                     spv_ff     <= sp_rd - 64'd8;
                     st_data_ff <= pc_ff + 64'd9;
                     mem_wr_ff  <= 1'b1;
                     wsp_ff     <= 1'b1;
                     pc_new_ff  <= it_ff.vc;
                     state_ff   <= S_ACHK;
                  end
                  CLS_RET: begin
                     spv_ff   <= sp_rd + 64'd8;
                     wsp_ff   <= 1'b1;
                     ld_pc_ff <= 1'b1;
                     state_ff <= S_ACHK;
                  end
                  CLS_JUMP: pc_new_ff <= cond_hit ? it_ff.vc : pc_ff + 64'd9;
                  CLS_ALU: begin
                     res_ff     <= alu_r;
                     flg_new_ff <= {alu_of, alu_r[63], alu_r == '0};
                     wres_ff    <= 1'b1;
                     pc_new_ff  <= pc_ff + 64'd2;
                  end
                  CLS_MUL: begin
                     ma_ff     <= a_ff[63] ? 64'd0 - a_ff : a_ff;
                     mb_ff     <= b_ff[63] ? 64'd0 - b_ff : b_ff;
                     neg_ff    <= a_ff[63] ^ b_ff[63];
                     pc_new_ff <= pc_ff + 64'd2;
                     state_ff  <= S_MUL;
                  end
                  CLS_DIV: begin
                     if (a_ff == '0) begin
                        st_ff <= ST_DIV0;
                     end else begin
                        pc_new_ff <= pc_ff + 64'd2;
                        state_ff  <= S_DIV;
                     end
                  end
                  CLS_CMOV: begin
                     wres_ff   <= cond_hit;
                     pc_new_ff <= pc_ff + 64'd2;
                  end
                  default: st_ff <= ST_INV;
               endcase
            end
            S_ACHK: begin
               if (!win_ok) begin
                  st_ff     <= ST_ADDR;
                  wres_ff   <= 1'b0;
                  wsp_ff    <= 1'b0;
                  pc_new_ff <= pc_ff;
                  state_ff  <= S_FIN;
               end else begin
                  off_ff   <= win_off[AW-1:0];
                  state_ff <= S_MEMOP;
               end
            end
            S_MEMOP: begin
               cnt_ff <= cnt_ff + 4'd1;
               if (mem_wr_ff) begin
                  st_data_ff <= {8'h00, st_data_ff[63:8]};
                  if (cnt_ff == LAST_STORE) begin
                     state_ff <= S_WBSP;
                  end
               end else begin
                  if (cnt_ff != 4'd0) begin
                     ld_ff <= ld_next;
                  end
                  if (cnt_ff == LAST_LOAD) begin
                     if (ld_res_ff) begin
                        res_ff <= ld_next;
                     end
                     if (ld_pc_ff) begin
                        pc_new_ff <= ld_next;
                     end
                     state_ff <= S_WBSP;
                  end
               end
            end
            S_MUL: begin
               mcnt_ff <= mcnt_ff + 3'd1;
               prod_ff <= mul_a_half * mul_b_half;
               unique case (mcnt_ff)
                  3'd1: acc_ff <= {64'd0, prod_ff};
                  3'd2, 3'd3: acc_ff <= acc_ff + {32'd0, prod_ff, 32'd0};
                  3'd4: begin
                     acc_ff   <= acc_ff + {prod_ff, 64'd0};
                     state_ff <= S_MULFIN;
                  end
                  default: acc_ff <= acc_ff;
               endcase
            end
            S_MULFIN: begin
               res_ff     <= mres;
               flg_new_ff <= {mof, mres[63], mres == '0};
               wres_ff    <= 1'b1;
               state_ff   <= S_WBRES;
            end
            S_DIV: begin
               if (div_done) begin
                  res_ff     <= div_r;
                  flg_new_ff <= {1'b0, div_r[63], div_r == '0};
                  wres_ff    <= 1'b1;
                  state_ff   <= S_WBRES;
               end
            end
            S_WBSP:  state_ff <= S_WBRES;
            S_WBRES: state_ff <= S_FIN;
            S_FIN: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= st_ff;
                  rsp_pc_ff     <= pc_new_ff;
                  rsp_flags_ff  <= flg_new_ff;
                  pc_ff         <= pc_new_ff;
                  flg_ff        <= flg_new_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_next_pc       = rsp_pc_ff;
   assign rsp_zero_flag     = rsp_flags_ff[0];
   assign rsp_sign_flag     = rsp_flags_ff[1];
   assign rsp_overflow_flag = rsp_flags_ff[2];

endmodule

>>> sv/y86_instruction_execute_top.sv
// Y86-64 instruction execute block: configuration registers, front end,
// queue and back end. Depends on y86_pkg, y86_front, y86_queue and y86_back.
//
// Usage: decoded instructions arrive as req_ transactions (valid/ready) and each
// one produces exactly one rsp_ transaction carrying status, next PC and flags.
// The csr_ port (APB-style, 64-bit data) holds mem_base at address 0 and
// mem_bytes_used at address 8; write it only while the block is idle.
// After reset a clearing pass zeroes the data memory, and req_ready stays low
// until it ends.
// Register, jump and ALU instructions go from execute straight to write-back;
// stores, push, call, loads, pop and ret first pass an address check and a
// memory pass (one memory byte per cycle), multiply forms four 32x32 partial
// products, and divide and modulo wait for the divider (one quotient bit per
// cycle). Instructions execute one at a time. A two-entry queue lets the front
// accept up to two further transactions while one executes, and a finished
// result waits in an output register while the receiver stalls.
module y86_instruction_execute_top #(
   parameter int MEM_BYTES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [4:0]  req_type,
   input  logic [3:0]  req_reg_a,
   input  logic [3:0]  req_reg_b,
   input  logic [63:0] req_const_val,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_next_pc,
   output logic        rsp_zero_flag,
   output logic        rsp_sign_flag,
   output logic        rsp_overflow_flag,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import y86_pkg::*;

   logic [63:0] mem_base_ff;
   logic [10:0] mem_used_ff;
   logic        csr_wr;
   logic        push, q_full, q_valid, q_pop, clearing;
   dec_type     dec, q_data;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[3] == CSR_MEM_USED) ? {53'd0, mem_used_ff} : mem_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_base_ff <= '0;
         mem_used_ff <= 11'd1024;
      end else if (csr_wr) begin
         if (csr_paddr[3] == CSR_MEM_USED) begin
            mem_used_ff <= csr_pwdata[10:0];
         end else begin
            mem_base_ff <= csr_pwdata;
         end
      end
   end

   y86_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_reg_a     (req_reg_a),
      .req_reg_b     (req_reg_b),
      .req_const_val (req_const_val),
      .q_full        (q_full),
      .clearing      (clearing),
      .push          (push),
      .dec           (dec)
   );

   y86_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (dec),
      .pop   (q_pop),
      .full  (q_full),
      .valid (q_valid),
      .rdata (q_data)
   );

   y86_back #(
      .MEM_BYTES (MEM_BYTES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_data            (q_data),
      .q_pop             (q_pop),
      .mem_base          (mem_base_ff),
      .mem_used          (mem_used_ff),
      .clearing          (clearing),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_next_pc       (rsp_next_pc),
      .rsp_zero_flag     (rsp_zero_flag),
      .rsp_sign_flag     (rsp_sign_flag),
      .rsp_overflow_flag (rsp_overflow_flag)
   );

   a_no_accept_while_clearing: assert property (
      @(posedge clock) disable iff (reset) clearing |-> !req_ready
   ) else $error("Transaction accepted during the memory clearing pass.");

   a_pop_only_when_valid: assert property (
      @(posedge clock) disable iff (reset) q_pop |-> q_valid
   ) else $error("Queue popped while empty.");

   a_csr_used_write: assert property (
      @(posedge clock) disable iff (reset)
      (csr_wr && (csr_paddr[3] == CSR_MEM_USED)) |=> (mem_used_ff == $past(csr_pwdata[10:0]))
   ) else $error("Window size register did not take the written value.");

endmodule

>>> bench/tb_y86_instruction_execute_top.sv
// Self-checking testbench for the Y86-64 instruction execute block.
// Drives decoded instructions with random idling and checks every result
// against a built-in predictor. Depends on y86_pkg and y86_instruction_execute_top.
module tb_y86_instruction_execute_top;
   import y86_pkg::*;

   localparam int MEM_SIZE = 1024;
   localparam int CYCLE_LIMIT = 2000000;
   localparam logic [3:0] ADDR_MEM_BASE = 4'd0;
   localparam logic [3:0] ADDR_MEM_USED = 4'd8;
   localparam logic [4:0] OP_INVALID = 5'd30;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] pc;
      logic        zf;
      logic        sf;
      logic        of;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [4:0]  req_type = '0;
   logic [3:0]  req_reg_a = '0;
   logic [3:0]  req_reg_b = '0;
   logic [63:0] req_const_val = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_next_pc;
   logic        rsp_zero_flag;
   logic        rsp_sign_flag;
   logic        rsp_overflow_flag;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   logic [63:0] regs [REG_COUNT];
   logic [7:0]  dmem [MEM_SIZE];
   logic [63:0] pc_model;
   logic        zf_m, sf_m, of_m;
   logic [63:0] base_m;
   logic [10:0] used_m;

   outcome_type pending_q[$];
   int          mismatches = 0;
   int          cycles = 0;
   bit          stall_free = 1'b0;

   y86_instruction_execute_top dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_y86_instruction_execute_top: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset)
         rsp_ready <= stall_free || ($urandom_range(99) >= 12);
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction status %0d", rsp_status);
         end else begin
            want = pending_q.pop_front();
            if (want != {rsp_status, rsp_next_pc, rsp_zero_flag, rsp_sign_flag,
                         rsp_overflow_flag}) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected st %0d pc %h zso %b%b%b, got st %0d pc %h zso %b%b%b",
                     want.status, want.pc, want.zf, want.sf, want.of, rsp_status, rsp_next_pc,
                     rsp_zero_flag, rsp_sign_flag, rsp_overflow_flag);
            end
         end
      end
   end

   function automatic bit window_hit(input logic [63:0] addr, output int offset);
      logic [63:0] size, off;
      size = (used_m > 11'(MEM_SIZE)) ? 64'(MEM_SIZE) : 64'(used_m);
      offset = 0;
      if (addr < base_m || size < 8) return 1'b0;
      off = addr - base_m;
      offset = int'(off[15:0]);
      return off <= size - 8;
   endfunction

   function automatic logic [63:0] read_word(input int offset);
      logic [63:0] v;
      for (int i = 0; i < 8; i++) v[8*i +: 8] = dmem[offset + i];
      return v;
   endfunction

   task automatic write_word(input int offset, input logic [63:0] v);
      for (int i = 0; i < 8; i++) dmem[offset + i] = v[8*i +: 8];
   endtask

   function automatic bit cond_true(input int which);
      bit lt;
      lt = sf_m ^ of_m;
      case (which)
         1: return zf_m;
         2: return !zf_m;
         3: return lt;
         4: return lt || zf_m;
         5: return !lt && !zf_m;
         6: return !lt;
         default: return 1'b1;
      endcase
   endfunction

   task automatic update_flags(input logic [63:0] r, input bit ovf);
      zf_m = (r == 0);
      sf_m = r[63];
      of_m = ovf;
   endtask

   task automatic execute_instruction(input logic [4:0] op, input logic [3:0] ra,
                                      input logic [3:0] rb, input logic [63:0] vc);
      logic [63:0]        a, b, sp, r;
      logic signed [127:0] prod;
      logic [2:0]         st;
      int                 off;
      a = regs[ra];
      b = regs[rb];
      sp = regs[SP_REG];
      st = ST_OK;
      case (op)
         OP_NOP: pc_model += 1;
         OP_HALT: st = ST_HALT;
         OP_RRMOVQ: begin regs[rb] = a; pc_model += 2; end
         OP_IRMOVQ: begin regs[rb] = vc; pc_model += 10; end
         OP_RMMOVQ: begin
            if (!window_hit(vc + b, off)) st = ST_ADDR;
            else begin write_word(off, a); pc_model += 10; end
         end
         OP_MRMOVQ: begin
            if (!window_hit(vc + b, off)) st = ST_ADDR;
            else begin regs[ra] = read_word(off); pc_model += 10; end
         end
         OP_PUSHQ: begin
            if (!window_hit(sp - 8, off)) st = ST_ADDR;
            else begin write_word(off, a); regs[SP_REG] = sp - 8; pc_model += 2; end
         end
         OP_POPQ: begin
            if (!window_hit(sp, off)) st = ST_ADDR;
            else begin regs[SP_REG] = sp + 8; regs[ra] = read_word(off); pc_model += 2; end
         end
         OP_CALL: begin
            if (!window_hit(sp - 8, off)) st = ST_ADDR;
            else begin
               write_word(off, pc_model + 9);
               regs[SP_REG] = sp - 8;
               pc_model = vc;
            end
         end
         OP_RET: begin
            if (!window_hit(sp, off)) st = ST_ADDR;
            else begin pc_model = read_word(off); regs[SP_REG] = sp + 8; end
         end
         OP_JMP, OP_JEQ, OP_JNE, OP_JL, OP_JLE, OP_JG, OP_JGE: begin
            if (cond_true(int'(op) - 10)) pc_model = vc;
            else pc_model += 9;
         end
         OP_ADDQ: begin
            r = b + a;
            update_flags(r, (a[63] == b[63]) && (r[63] != b[63]));
            regs[rb] = r; pc_model += 2;
         end
         OP_SUBQ: begin
            r = b - a;
            update_flags(r, (a[63] != b[63]) && (r[63] != b[63]));
            regs[rb] = r; pc_model += 2;
         end
         OP_MULQ: begin
            prod = $signed(a) * $signed(b);
            r = prod[63:0];
            update_flags(r, prod != {{64{r[63]}}, r});
            regs[rb] = r; pc_model += 2;
         end
         OP_MODQ, OP_DIVQ: begin
            if (a == 0) st = ST_DIV0;
            else begin
               r = (op == OP_MODQ) ? b % a : b / a;
               update_flags(r, 1'b0);
               regs[rb] = r; pc_model += 2;
            end
         end
         OP_ANDQ: begin r = b & a; update_flags(r, 1'b0); regs[rb] = r; pc_model += 2; end
         OP_XORQ: begin r = b ^ a; update_flags(r, 1'b0); regs[rb] = r; pc_model += 2; end
         OP_CMOVEQ, OP_CMOVNE, OP_CMOVL, OP_CMOVLE, OP_CMOVG, OP_CMOVGE: begin
            if (cond_true(int'(op) - 23)) regs[rb] = a;
            pc_model += 2;
         end
         default: st = ST_INV;
      endcase
      pending_q.push_back('{st, pc_model, zf_m, sf_m, of_m});
   endtask

   task automatic send_instruction(input logic [4:0] op, input logic [3:0] ra,
                                   input logic [3:0] rb, input logic [63:0] vc);
      while (!stall_free && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_reg_a <= ra;
      req_reg_b <= rb;
      req_const_val <= vc;
      execute_instruction(op, ra, rb, vc);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic csr_write(input logic [3:0] addr, input logic [63:0] data);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_MEM_BASE) base_m = data;
      else used_m = data[10:0];
      @(posedge clock);
   endtask

   function automatic logic [63:0] random_word;
      case ($urandom_range(5))
         0: return 64'd0;
         1: return '1;
         2: return SIGN64;
         3: return 64'($urandom_range(15));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic set_window(input logic [63:0] base, input logic [10:0] used);
      drain();
      csr_write(ADDR_MEM_BASE, base);
      csr_write(ADDR_MEM_USED, {53'd0, used});
   endtask

   task automatic test_directed;
      send_instruction(OP_NOP, 4'd0, 4'd0, 64'd0);
      send_instruction(OP_HALT, 4'd0, 4'd0, 64'd0);
      send_instruction(OP_IRMOVQ, 4'd15, 4'd4, 64'd1024);
      send_instruction(OP_IRMOVQ, 4'd15, 4'd1, '1);
      send_instruction(OP_IRMOVQ, 4'd15, 4'd2, SIGN64);
      send_instruction(OP_IRMOVQ, 4'd15, 4'd0, 64'd0);
      send_instruction(OP_ADDQ, 4'd2, 4'd2, 64'd0);
      send_instruction(OP_CMOVEQ, 4'd1, 4'd15, 64'd0);
      send_instruction(OP_SUBQ, 4'd1, 4'd2, 64'd0);
      send_instruction(OP_MULQ, 4'd1, 4'd1, 64'd0);
      send_instruction(OP_DIVQ, 4'd0, 4'd1, 64'd0);
      send_instruction(OP_MODQ, 4'd0, 4'd1, 64'd0);
      send_instruction(OP_PUSHQ, 4'd4, 4'd0, 64'd0);
      send_instruction(OP_POPQ, 4'd4, 4'd0, 64'd0);
      send_instruction(OP_CALL, 4'd0, 4'd0, 64'h40);
      send_instruction(OP_RET, 4'd0, 4'd0, 64'd0);
      send_instruction(OP_RMMOVQ, 4'd1, 4'd0, 64'd1016);
      send_instruction(OP_MRMOVQ, 4'd3, 4'd0, 64'd1016);
      send_instruction(OP_MRMOVQ, 4'd3, 4'd0, 64'd1017);
      send_instruction(OP_JL, 4'd0, 4'd0, '1);
      send_instruction(OP_JGE, 4'd0, 4'd0, 64'h100);
      send_instruction(OP_INVALID, 4'd0, 4'd0, 64'd0);
      send_instruction(5'd31, 4'd0, 4'd0, 64'd0);
   endtask

   task automatic test_random(input int count);
      logic [4:0] op;
      logic [63:0] vc;
      for (int i = 0; i < count; i++) begin
         stall_free = (i >= count / 2) && (i < count / 2 + 60);
         op = 5'($urandom_range(31));
         vc = random_word();
         if (op == OP_RMMOVQ || op == OP_MRMOVQ) vc = base_m + 8 * $urandom_range(140);
         if ($urandom_range(9) == 0) vc = random_word();
         if (op == OP_IRMOVQ && $urandom_range(2) == 0) begin
            send_instruction(op, 4'($urandom), 4'd4, base_m + 8 * $urandom_range(1, 128));
         end else begin
            send_instruction(op, 4'($urandom), ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom), vc);
         end
      end
      stall_free = 1'b0;
   endtask

   initial begin
      foreach (regs[i]) regs[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      pc_model = '0;
      {zf_m, sf_m, of_m} = '0;
      base_m = '0;
      used_m = 11'd1024;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      set_window(64'h1000, 11'd1024);
      test_random(120);
      set_window('1 - 64'd511, 11'd2047);
      test_random(80);
      set_window(64'd0, 11'd7);
      test_random(60);
      set_window(64'd64, 11'd512);
      test_random(130);
      set_window(64'd0, 11'd1024);
      test_random(60);
      drain();
      if (mismatches == 0) $display("tb_y86_instruction_execute_top: done, clean");
      else $display("tb_y86_instruction_execute_top: done, errors");
      $finish;
   end
endmodule
